@@ rtl/core/mexp_pkg.sv @@
`timescale 1ns / 1ps
package mexp_pkg;
  localparam int WORD_BITS = 64;
  localparam logic [WORD_BITS-1:0] MODULUS_RESET = 64'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MULT,
    ST_SQUARE,
    ST_DONE
  } state_t;
endpackage

@@ rtl/core/modular_exponentiation_64.sv @@
`timescale 1ns / 1ps
// time from accept to m_tvalid grows with the number of exponent bits set; the work is done
// by the shared shift-add-reduce unit, which handles one multiplier bit per cycle
// throughput: one word at a time; s_tready returns in the cycle after the result is taken
// reset: synchronous active-high rst clears control state and sets modulus to 2
module modular_exponentiation_64 #(
  parameter int WORD_BITS = mexp_pkg::WORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [WORD_BITS-1:0]         cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // s_tdata: exponent (upper half), base_value (lower half)
  input  logic [2*WORD_BITS-1:0]       s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // m_tdata: power_result
  output logic [WORD_BITS-1:0]         m_tdata
);
  localparam int CW = $clog2(WORD_BITS + 1);

  mexp_pkg::state_t state, state_next;
  logic [WORD_BITS-1:0] modulus, base, expo, res, acc, a_op, b_op;
  logic [CW-1:0] bit_cnt, step_cnt;
  logic          small_mod;

  // shared unit: acc = 2*acc + bit (reduce) or 2*acc + bit*a (product), mod m
  logic [WORD_BITS:0] dbl, dbl_r, add1, add1_r;
  logic               cur_bit;
  logic [WORD_BITS-1:0] addend;
  always_comb begin
    cur_bit = b_op[bit_cnt[$clog2(WORD_BITS)-1:0] - 1'b1];
    dbl = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    addend = (state == mexp_pkg::ST_REDUCE) ? {{(WORD_BITS-1){1'b0}}, cur_bit}
                                            : (cur_bit ? a_op : '0);
    add1 = dbl_r + {1'b0, addend};
    add1_r = (add1 >= {1'b0, modulus}) ? add1 - {1'b0, modulus} : add1;
  end

  assign s_tready = (state == mexp_pkg::ST_IDLE);
  // keep a register write off the edge that takes a word
  assign cfg_ready = (state == mexp_pkg::ST_IDLE) && !s_tvalid;
  assign m_tvalid = (state == mexp_pkg::ST_DONE);
  assign m_tdata = small_mod ? '0 : res;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mexp_pkg::ST_IDLE:   if (s_tvalid) state_next = mexp_pkg::ST_REDUCE;
      mexp_pkg::ST_REDUCE: if (bit_cnt == CW'(1)) state_next = mexp_pkg::ST_STEP;
      mexp_pkg::ST_STEP:
        if (step_cnt == CW'(WORD_BITS)) state_next = mexp_pkg::ST_DONE;
        else if (expo[0]) state_next = mexp_pkg::ST_MULT;
        else state_next = mexp_pkg::ST_SQUARE;
      mexp_pkg::ST_MULT:   if (bit_cnt == CW'(1)) state_next = mexp_pkg::ST_SQUARE;
      mexp_pkg::ST_SQUARE: if (bit_cnt == CW'(1)) state_next = mexp_pkg::ST_STEP;
      mexp_pkg::ST_DONE:   if (m_tready) state_next = mexp_pkg::ST_IDLE;
      default:             state_next = mexp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mexp_pkg::ST_IDLE;
      modulus <= mexp_pkg::MODULUS_RESET[WORD_BITS-1:0];
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) modulus <= cfg_data;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      mexp_pkg::ST_IDLE: if (s_tvalid) begin
        b_op <= s_tdata[WORD_BITS-1:0];
        expo <= s_tdata[2*WORD_BITS-1:WORD_BITS];
        acc <= '0;
        bit_cnt <= CW'(WORD_BITS);
        step_cnt <= '0;
        res <= {{(WORD_BITS-1){1'b0}}, 1'b1};
        small_mod <= (modulus < WORD_BITS'(2));
      end
      mexp_pkg::ST_REDUCE, mexp_pkg::ST_MULT, mexp_pkg::ST_SQUARE: begin
        if (state == mexp_pkg::ST_MULT && bit_cnt == CW'(1)) begin
          // product done, set up the square of the base
          res <= add1_r[WORD_BITS-1:0];
          a_op <= base;
          b_op <= base;
          acc <= '0;
          bit_cnt <= CW'(WORD_BITS);
        end else begin
          if (!small_mod) acc <= add1_r[WORD_BITS-1:0];
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == CW'(1)) begin
            base <= add1_r[WORD_BITS-1:0];
            if (state == mexp_pkg::ST_SQUARE) begin
              expo <= expo >> 1;
              step_cnt <= step_cnt + 1'b1;
            end
          end
        end
      end
      mexp_pkg::ST_STEP: begin
        acc <= '0;
        bit_cnt <= CW'(WORD_BITS);
        a_op <= expo[0] ? res : base;
        b_op <= base;
      end
      default: ;
    endcase
  end

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("ready while result pending");
  a_accept_leaves: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("accept did not start work");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result lost before taken");
endmodule
